// ===== rtl/core/ber_tlv_stream_decoder_defines.svh =====
// Assertion macros shared by the BER TLV decoder RTL.
`ifndef BER_TLV_STREAM_DECODER_DEFINES_SVH
`define BER_TLV_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define BTLV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define BTLV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/btlv_pkg.sv =====
// Types and constants of the BER TLV stream decoder.
`default_nettype none

package btlv_pkg;

  // Parser phase within one TLV.
  typedef enum logic [2:0] {
    PH_ID,
    PH_TAG,
    PH_LEN,
    PH_LENX,
    PH_DATA,
    PH_DROP
  } btlv_phase_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_CONTENT,
    KIND_EOC,
    KIND_ERROR
  } btlv_kind_t;

  // Error codes.
  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_TRUNCATED,
    ERR_TAG_LONG,
    ERR_LEN_LONG
  } btlv_err_t;

  // Low identifier bits that announce a multi-byte tag.
  localparam logic [4:0] TAG_ESCAPE = 5'h1f;
  // Bit that marks continuation in tags and long form in lengths.
  localparam int HIGH_BIT = 7;

  // Input transaction payload.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       buf_end;
  } btlv_in_t;

  // Output transaction payload.
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  tag_class;
    logic        is_constructed;
    logic [31:0] tag_number;
    logic [31:0] content_length;
    logic [7:0]  data_byte;
    logic        last_content;
    logic [1:0]  error_code;
  } btlv_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/btlv_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
`default_nettype none

interface btlv_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ber_tlv_stream_decoder.sv =====
// BER TLV stream decoder: parses identifier, length and content bytes of a buffer.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   in_ch    | sink      | in_byte, buf_end
//   out_ch   | source    | kind, tag_class, is_constructed, tag_number,
//            |           | content_length, data_byte, last_content, error_code
//
// One byte is taken per cycle while not stalled; its result, if any, is registered.
// All decoding happens between the parser state registers and the output register.
// A two-entry output buffer (output register plus skid register) lets a byte be
// taken while a result waits; input stalls only when both entries are full.
// Synchronous reset returns the parser to the identifier phase and empties the buffer.
`default_nettype none

`include "ber_tlv_stream_decoder_defines.svh"

module ber_tlv_stream_decoder
  import btlv_pkg::*;
#(
  parameter int MAX_TAG_BYTES    = 5,
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  btlv_stream_if.sink   in_ch,
  btlv_stream_if.source out_ch
);

  localparam int MaxField = (MAX_TAG_BYTES > MAX_LENGTH_BYTES) ?
                            MAX_TAG_BYTES : MAX_LENGTH_BYTES;
  localparam int CntW     = $clog2(MaxField + 1);

  // Parser state.
  btlv_phase_t phase, phase_next;
  logic [1:0]  class_bits, class_bits_next;
  logic        constructed_bit, constructed_bit_next;
  logic [31:0] tag_accum, tag_accum_next;
  logic [31:0] length_accum, length_accum_next;
  logic [CntW-1:0] field_bytes_left, field_bytes_left_next;
  logic [31:0] content_left, content_left_next;
  logic        first_zero_seen, first_zero_seen_next;

  // Output buffer.
  logic      out_valid;
  btlv_out_t out_data;
  logic      skid_valid;
  btlv_out_t skid_data;

  // Result of the byte at the input.
  logic      res_valid;
  btlv_out_t res;

  logic       in_fire;
  logic [7:0] b;
  logic       end_flag;

  assign in_ch.ready    = !skid_valid;
  assign in_fire        = in_ch.valid && in_ch.ready;
  assign b              = in_ch.payload.in_byte;
  assign end_flag       = in_ch.payload.buf_end;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_data;

  // Shared decode of the current byte.
  logic            long_tag;
  logic            tag_ovf;
  logic [31:0]     tag_new;
  logic [CntW-1:0] fbl_dec;
  logic [6:0]      len_cnt;
  logic            len_cnt_big;
  logic            len_ovf;
  logic [31:0]     len_new;
  logic [31:0]     cl_dec;
  logic [31:0]     hdr_len;
  logic            hdr_eoc;

  assign long_tag    = (b[4:0] == TAG_ESCAPE);
  assign tag_ovf     = (tag_accum[31:25] != 7'd0);
  assign tag_new     = {tag_accum[24:0], b[6:0]};
  assign fbl_dec     = field_bytes_left - CntW'(1);
  assign len_cnt     = b[6:0];
  assign len_cnt_big = (len_cnt > 7'(MAX_LENGTH_BYTES));
  assign len_ovf     = (length_accum[31:24] != 8'd0);
  assign len_new     = {length_accum[23:0], b};
  assign cl_dec      = content_left - 32'd1;

  // Length of a header completed by this byte; long form ends through PH_LENX.
  assign hdr_len = (phase == PH_LENX) ? len_new :
                   (b[HIGH_BIT] ? 32'd0 : {24'd0, b});
  // Two zero bytes make an end-of-contents marker.
  assign hdr_eoc = (phase == PH_LEN) && first_zero_seen && (b == 8'h00);

  // Next parser state.
  always_comb begin
    phase_next            = phase;
    class_bits_next       = class_bits;
    constructed_bit_next  = constructed_bit;
    tag_accum_next        = tag_accum;
    length_accum_next     = length_accum;
    field_bytes_left_next = field_bytes_left;
    content_left_next     = content_left;
    first_zero_seen_next  = first_zero_seen;
    case (phase)
      PH_ID: begin
        class_bits_next      = b[7:6];
        constructed_bit_next = b[5];
        first_zero_seen_next = (b == 8'h00);
        if (long_tag) begin
          tag_accum_next        = 32'd0;
          field_bytes_left_next = CntW'(MAX_TAG_BYTES);
          phase_next            = PH_TAG;
        end else begin
          tag_accum_next = {27'd0, b[4:0]};
          phase_next     = PH_LEN;
        end
      end
      PH_TAG: begin
        if (tag_ovf) begin
          phase_next = PH_DROP;
        end else begin
          tag_accum_next        = tag_new;
          field_bytes_left_next = fbl_dec;
          if (!b[HIGH_BIT]) begin
            phase_next = PH_LEN;
          end else if (fbl_dec == '0) begin
            phase_next = PH_DROP;
          end
        end
      end
      PH_LEN: begin
        if (b[HIGH_BIT] && len_cnt != 7'd0) begin
          if (len_cnt_big) begin
            phase_next = PH_DROP;
          end else begin
            length_accum_next     = 32'd0;
            field_bytes_left_next = len_cnt[CntW-1:0];
            phase_next            = PH_LENX;
          end
        end else begin
          first_zero_seen_next = 1'b0;
          if (!hdr_eoc && hdr_len != 32'd0 && !constructed_bit) begin
            content_left_next = hdr_len;
            phase_next        = PH_DATA;
          end else begin
            phase_next = PH_ID;
          end
        end
      end
      PH_LENX: begin
        if (len_ovf) begin
          phase_next = PH_DROP;
        end else begin
          length_accum_next     = len_new;
          field_bytes_left_next = fbl_dec;
          if (fbl_dec == '0) begin
            first_zero_seen_next = 1'b0;
            if (hdr_len != 32'd0 && !constructed_bit) begin
              content_left_next = hdr_len;
              phase_next        = PH_DATA;
            end else begin
              phase_next = PH_ID;
            end
          end
        end
      end
      PH_DATA: begin
        content_left_next = cl_dec;
        if (cl_dec == 32'd0) begin
          phase_next = PH_ID;
        end
      end
      default: begin
      end
    endcase
    // The last byte of a buffer returns everything to the reset state.
    if (end_flag) begin
      phase_next            = PH_ID;
      class_bits_next       = 2'd0;
      constructed_bit_next  = 1'b0;
      tag_accum_next        = 32'd0;
      length_accum_next     = 32'd0;
      field_bytes_left_next = '0;
      content_left_next     = 32'd0;
      first_zero_seen_next  = 1'b0;
    end
  end

  // Result of the current byte.
  btlv_out_t hdr_res;
  btlv_out_t err_res;
  btlv_err_t err_code;

  always_comb begin
    hdr_res = '0;
    if (hdr_eoc) begin
      hdr_res.kind = KIND_EOC;
    end else begin
      hdr_res.kind           = KIND_HEADER;
      hdr_res.tag_class      = class_bits;
      hdr_res.is_constructed = constructed_bit;
      hdr_res.tag_number     = tag_accum;
      hdr_res.content_length = hdr_len;
      hdr_res.error_code     = (end_flag && hdr_len != 32'd0) ? ERR_TRUNCATED : ERR_NONE;
    end
  end

  // Error code of the current byte; truncation unless a field is too long.
  always_comb begin
    err_code = ERR_TRUNCATED;
    case (phase)
      PH_TAG: begin
        if (tag_ovf || (b[HIGH_BIT] && fbl_dec == '0)) begin
          err_code = ERR_TAG_LONG;
        end
      end
      PH_LEN: begin
        if (b[HIGH_BIT] && len_cnt != 7'd0 && len_cnt_big) begin
          err_code = ERR_LEN_LONG;
        end
      end
      PH_LENX: begin
        if (len_ovf) begin
          err_code = ERR_LEN_LONG;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    err_res            = '0;
    err_res.kind       = KIND_ERROR;
    err_res.error_code = err_code;
  end

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (phase)
      PH_ID: begin
        res_valid = end_flag;
        res       = err_res;
      end
      PH_TAG: begin
        if (tag_ovf || (b[HIGH_BIT] && fbl_dec == '0)) begin
          res_valid = 1'b1;
        end else begin
          res_valid = end_flag;
        end
        res = err_res;
      end
      PH_LEN: begin
        if (b[HIGH_BIT] && len_cnt != 7'd0) begin
          if (len_cnt_big) begin
            res_valid = 1'b1;
          end else begin
            res_valid = end_flag;
          end
          res = err_res;
        end else begin
          res_valid = 1'b1;
          res       = hdr_res;
        end
      end
      PH_LENX: begin
        if (len_ovf) begin
          res_valid = 1'b1;
          res       = err_res;
        end else if (fbl_dec == '0) begin
          res_valid = 1'b1;
          res       = hdr_res;
        end else begin
          res_valid = end_flag;
          res       = err_res;
        end
      end
      PH_DATA: begin
        res_valid          = 1'b1;
        res.kind           = KIND_CONTENT;
        res.data_byte      = b;
        res.last_content   = (cl_dec == 32'd0);
        res.error_code     = (end_flag && cl_dec != 32'd0) ? ERR_TRUNCATED : ERR_NONE;
      end
      default: begin
      end
    endcase
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_ID;
      class_bits       <= 2'd0;
      constructed_bit  <= 1'b0;
      tag_accum        <= 32'd0;
      length_accum     <= 32'd0;
      field_bytes_left <= '0;
      content_left     <= 32'd0;
      first_zero_seen  <= 1'b0;
    end else if (in_fire) begin
      phase            <= phase_next;
      class_bits       <= class_bits_next;
      constructed_bit  <= constructed_bit_next;
      tag_accum        <= tag_accum_next;
      length_accum     <= length_accum_next;
      field_bytes_left <= field_bytes_left_next;
      content_left     <= content_left_next;
      first_zero_seen  <= first_zero_seen_next;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ch.ready) begin
      if (in_fire && res_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ch.ready) begin
      if (in_fire && res_valid) begin
        skid_data <= res;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (in_fire && res_valid) begin
      out_data <= res;
    end
  end

  // Checks on the parser and the output buffer.
  `BTLV_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid,
                   "skid entry full while output empty")
  `BTLV_ASSERT_NEXT(a_end_resets, in_fire && end_flag,
                    phase == PH_ID && !first_zero_seen,
                    "buffer end did not reset the parser")
  `BTLV_ASSERT_NOW(a_data_nonzero, phase == PH_DATA, content_left != 32'd0,
                   "content phase with no bytes left")
  `BTLV_ASSERT_NEXT(a_error_drops,
                    in_fire && res_valid && res.kind == KIND_ERROR && !end_flag,
                    phase == PH_DROP, "error did not enter drop phase")

endmodule

`default_nettype wire

// ===== tb/ber_tlv_decode_checker.sv =====
// Checker that predicts the BER TLV decoder's results and compares them with its output.
module ber_tlv_decode_checker
  import btlv_pkg::*;
#(
  parameter int MAX_TAG_BYTES    = 5,
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  btlv_in_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  btlv_out_t out_item,
  output int        mismatches,
  output int        pending,
  output int        parsed_bytes
);

  // Length byte that opens the long form; also stands in for it when a long length closes.
  localparam logic [7:0] LONG_FORM_MARK = 8'h80;

  // Parser state of the prediction.
  btlv_phase_t phase;
  logic [1:0]  id_class;
  logic        id_constructed;
  logic [31:0] tag_acc;
  logic [31:0] len_acc;
  logic [3:0]  bytes_left;
  logic [31:0] content_left;
  logic        zero_id;

  // Decoded results still waiting for their output transaction.
  btlv_out_t   expected_q[$];
  int          mismatch_total;
  int          parsed_total;
  int          result_index;

  task automatic clear_state();
    phase          = PH_ID;
    id_class       = '0;
    id_constructed = 1'b0;
    tag_acc        = '0;
    len_acc        = '0;
    bytes_left     = '0;
    content_left   = '0;
    zero_id        = 1'b0;
  endtask

  function automatic btlv_out_t blank_result(btlv_kind_t kind);
    btlv_out_t r;
    r      = '0;
    r.kind = kind;
    return r;
  endfunction

  // An error is reported on its own and the rest of the buffer is dropped.
  task automatic flag_error(input btlv_err_t code, output logic hit, output btlv_out_t res);
    res            = blank_result(KIND_ERROR);
    res.error_code = code;
    hit            = 1'b1;
    phase          = PH_DROP;
  endtask

  // The length is complete: either an end-of-contents marker or a header.
  task automatic close_header(input logic [31:0] len, input logic [7:0] len_byte,
                              input logic fin, output logic hit, output btlv_out_t res);
    if (zero_id && len_byte == 8'h00) begin
      res   = blank_result(KIND_EOC);
      phase = PH_ID;
    end else begin
      res                = blank_result(KIND_HEADER);
      res.tag_class      = id_class;
      res.is_constructed = id_constructed;
      res.tag_number     = tag_acc;
      res.content_length = len;
      res.error_code     = (fin && len != 0) ? ERR_TRUNCATED : ERR_NONE;
      // Constructed values carry nested TLVs, so only primitives enter the content phase.
      if (len != 0 && !id_constructed) begin
        content_left = len;
        phase        = PH_DATA;
      end else begin
        phase = PH_ID;
      end
    end
    hit     = 1'b1;
    zero_id = 1'b0;
  endtask

  // Advances the parser by one buffer byte and gives the result it causes, if any.
  task automatic decode_byte(input logic [7:0] b, input logic fin,
                             output logic hit, output btlv_out_t res);
    logic [6:0] octets;
    logic       last;
    hit = 1'b0;
    res = '0;
    case (phase)
      PH_ID: begin
        id_class       = b[7:6];
        id_constructed = b[5];
        zero_id        = (b == 8'h00);
        if (b[4:0] == TAG_ESCAPE) begin
          tag_acc    = '0;
          bytes_left = 4'(MAX_TAG_BYTES);
          phase      = PH_TAG;
        end else begin
          tag_acc = {27'd0, b[4:0]};
          phase   = PH_LEN;
        end
        if (fin) flag_error(ERR_TRUNCATED, hit, res);
      end
      PH_TAG: begin
        if (tag_acc[31:25] != 0) begin
          flag_error(ERR_TAG_LONG, hit, res);
        end else begin
          tag_acc    = {tag_acc[24:0], b[6:0]};
          bytes_left = bytes_left - 4'd1;
          if (b[HIGH_BIT]) begin
            if (bytes_left == 0) flag_error(ERR_TAG_LONG, hit, res);
            else if (fin) flag_error(ERR_TRUNCATED, hit, res);
          end else begin
            phase = PH_LEN;
            if (fin) flag_error(ERR_TRUNCATED, hit, res);
          end
        end
      end
      PH_LEN: begin
        if (b[HIGH_BIT]) begin
          octets = b[6:0];
          if (octets == 0) begin
            close_header(32'd0, b, fin, hit, res);
          end else if (octets > MAX_LENGTH_BYTES) begin
            flag_error(ERR_LEN_LONG, hit, res);
          end else begin
            len_acc    = '0;
            bytes_left = octets[3:0];
            phase      = PH_LENX;
            if (fin) flag_error(ERR_TRUNCATED, hit, res);
          end
        end else begin
          close_header({24'd0, b}, b, fin, hit, res);
        end
      end
      PH_LENX: begin
        if (len_acc[31:24] != 0) begin
          flag_error(ERR_LEN_LONG, hit, res);
        end else begin
          len_acc    = {len_acc[23:0], b};
          bytes_left = bytes_left - 4'd1;
          if (bytes_left == 0) close_header(len_acc, LONG_FORM_MARK, fin, hit, res);
          else if (fin) flag_error(ERR_TRUNCATED, hit, res);
        end
      end
      PH_DATA: begin
        content_left     = content_left - 32'd1;
        last             = (content_left == 0);
        res              = blank_result(KIND_CONTENT);
        res.data_byte    = b;
        res.last_content = last;
        res.error_code   = (fin && !last) ? ERR_TRUNCATED : ERR_NONE;
        hit              = 1'b1;
        if (last) phase = PH_ID;
      end
      default: ;
    endcase
    // The end of a buffer always returns the parser to its starting state.
    if (fin) clear_state();
  endtask

  // Output transactions are checked before the input of the same edge is decoded,
  // since a result never leaves in the cycle its byte is taken.
  always @(posedge clk) begin
    btlv_out_t want;
    btlv_out_t res;
    logic      hit;
    if (rst) begin
      clear_state();
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("result %0d arrived with nothing expected: kind %0d tag %0h len %0h",
                     result_index, out_item.kind, out_item.tag_number,
                     out_item.content_length);
        end else begin
          want = expected_q.pop_front();
          if (out_item.kind !== want.kind || out_item.tag_class !== want.tag_class ||
              out_item.is_constructed !== want.is_constructed ||
              out_item.tag_number !== want.tag_number ||
              out_item.content_length !== want.content_length ||
              out_item.data_byte !== want.data_byte ||
              out_item.last_content !== want.last_content ||
              out_item.error_code !== want.error_code) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
              $display("result %0d mismatch (expected / actual):", result_index);
              $display("  kind %0d/%0d class %0d/%0d constructed %0d/%0d err %0d/%0d",
                       want.kind, out_item.kind, want.tag_class, out_item.tag_class,
                       want.is_constructed, out_item.is_constructed,
                       want.error_code, out_item.error_code);
              $display("  tag %0h/%0h len %0h/%0h data %0h/%0h last %0d/%0d",
                       want.tag_number, out_item.tag_number,
                       want.content_length, out_item.content_length,
                       want.data_byte, out_item.data_byte,
                       want.last_content, out_item.last_content);
            end
          end
        end
        result_index++;
      end
      if (in_valid && in_ready) begin
        if (phase != PH_DROP) parsed_total++;
        decode_byte(in_item.in_byte, in_item.buf_end, hit, res);
        if (hit) expected_q.push_back(res);
      end
    end
    mismatches   <= mismatch_total;
    pending      <= expected_q.size();
    parsed_bytes <= parsed_total;
  end

endmodule

// ===== tb/ber_tlv_stream_decoder_test.sv =====
// Top of the BER TLV decoder testbench: clock, reset, byte stimulus and the verdict.
module ber_tlv_stream_decoder_test
  import btlv_pkg::*;
();

  localparam int RANDOM_ITEMS = 1900;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [7:0] LONG_FORM_MARK = 8'h80;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  int         mismatches;
  int         pending;
  int         parsed_bytes;
  logic [7:0] buf_q[$];
  logic       in_idle_mode  = 1'b1;
  logic       out_idle_mode = 1'b1;

  btlv_stream_if #(.payload_t(btlv_in_t))  in_ch ();
  btlv_stream_if #(.payload_t(btlv_out_t)) out_ch ();

  ber_tlv_stream_decoder i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ber_tlv_decode_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_item      (in_ch.payload),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_item     (out_ch.payload),
    .mismatches   (mismatches),
    .pending      (pending),
    .parsed_bytes (parsed_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one byte after a random gap and returns at the edge that takes it.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if ($urandom_range(0, 63) == 0) in_idle_mode = !in_idle_mode;
    gap = in_idle_mode ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= '{in_byte: b, buf_end: fin};
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // Sends the assembled buffer, flagging its final byte.
  task automatic send_buffer();
    for (int i = 0; i < buf_q.size(); i++) send_byte(buf_q[i], i == buf_q.size() - 1);
    buf_q.delete();
  endtask

  // Appends one TLV; cut is set when the buffer has to end inside its content.
  task automatic add_tlv(output bit cut);
    logic [1:0]  cls;
    logic        cons;
    int          tag_bytes;
    int          octets;
    logic [31:0] len_val;
    cut = 1'b0;
    if ($urandom_range(0, 19) == 0) begin
      buf_q.push_back(8'h00);
      buf_q.push_back(8'h00);
      return;
    end
    cls  = 2'($urandom);
    cons = ($urandom_range(0, 3) == 0);

    // Identifier: mostly short tags, some multi-byte ones and a few over-long ones.
    tag_bytes = 0;
    if ($urandom_range(0, 2) == 0)
      tag_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
    if (tag_bytes == 0) begin
      buf_q.push_back({cls, cons, 5'($urandom_range(0, 30))});
    end else begin
      buf_q.push_back({cls, cons, TAG_ESCAPE});
      for (int i = tag_bytes - 1; i >= 0; i--) buf_q.push_back({i != 0, 7'($urandom)});
    end

    // Length: short, long with small values, indefinite, huge, or too many octets.
    len_val = cons ? 32'($urandom_range(0, 40)) : 32'($urandom_range(0, 6));
    case ($urandom_range(0, 19))
      0, 1: begin
        buf_q.push_back(LONG_FORM_MARK);
        len_val = '0;
      end
      2: begin
        octets  = $urandom_range(1, 4);
        len_val = $urandom >> (8 * (4 - octets));
        buf_q.push_back(LONG_FORM_MARK | 8'(octets));
        for (int i = octets - 1; i >= 0; i--) buf_q.push_back(8'(len_val >> (8 * i)));
        cut = !cons;
      end
      3: begin
        buf_q.push_back(LONG_FORM_MARK | 8'($urandom_range(5, 127)));
        len_val = '0;
      end
      4, 5, 6, 7: begin
        octets = $urandom_range(1, 4);
        buf_q.push_back(LONG_FORM_MARK | 8'(octets));
        for (int i = octets - 1; i >= 0; i--) buf_q.push_back(8'(len_val >> (8 * i)));
      end
      default: buf_q.push_back(len_val[7:0]);
    endcase

    // Content of a primitive value; a huge length is only partly sent.
    if (cut) repeat ($urandom_range(0, 3)) buf_q.push_back(8'($urandom));
    else if (!cons) repeat (len_val) buf_q.push_back(8'($urandom));
  endtask

  // Builds and sends one random buffer: mostly well formed, some noise, some cut short.
  task automatic send_random_buffer();
    int tlvs;
    bit cut;
    cut = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) buf_q.push_back(8'($urandom));
    end else begin
      tlvs = $urandom_range(1, 5);
      for (int t = 0; t < tlvs && !cut; t++) add_tlv(cut);
      if ($urandom_range(0, 9) == 0 && buf_q.size() > 1)
        repeat ($urandom_range(1, buf_q.size() - 1)) void'(buf_q.pop_back());
    end
    send_buffer();
  endtask

  // Stimulus: directed buffers first, then random buffers, then the verdict.
  initial begin
    int directed_bytes;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Short length with a single, final content byte.
    buf_q = {8'h02, 8'h01, 8'hFF};
    send_buffer();
    // Constructed value of indefinite length closed by end-of-contents.
    buf_q = {8'h30, 8'h80, 8'h00, 8'h00};
    send_buffer();
    // Private class, two-byte tag, four-octet maximum length; buffer ends on the header.
    buf_q = {8'hDF, 8'hFF, 8'h7F, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_buffer();
    // Buffer ends inside a multi-byte tag.
    buf_q = {8'h5F, 8'h81};
    send_buffer();
    // More tag bytes than allowed; the tag error on the final byte wins over truncation.
    buf_q = {8'h9F, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81};
    send_buffer();
    // Too many length octets on the final byte wins over truncation.
    buf_q = {8'h04, 8'h85};
    send_buffer();
    // Buffer ends inside the content.
    buf_q = {8'h04, 8'h03, 8'h00, 8'h11};
    send_buffer();

    directed_bytes = parsed_bytes;
    while (parsed_bytes < directed_bytes + RANDOM_ITEMS) send_random_buffer();
    in_ch.valid <= 1'b0;

    // Wait for every outstanding result, then keep watching for anything unexpected.
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Result receiver: random stalls, plus one long hold-off that fills the block.
  initial begin
    int gap;
    int taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AFTER) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) out_idle_mode = !out_idle_mode;
      gap = out_idle_mode ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      taken++;
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
